>>> rtl/core/wbcc_pkg.sv
`default_nettype none

package wbcc_pkg;

    // default sizes
    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 32;

    // bits of the id consumed per cycle by the remainder unit
    localparam int MOD_DIGITS = 4;

    // active slot register after reset
    localparam logic [4:0] ACTIVE_RESET = 5'd16;

    // operation codes
    localparam logic [2:0] KIND_GET         = 3'd0;
    localparam logic [2:0] KIND_CLAIM       = 3'd1;
    localparam logic [2:0] KIND_DIRTY_ID    = 3'd2;
    localparam logic [2:0] KIND_DIRTY_SLOT  = 3'd3;
    localparam logic [2:0] KIND_FLUSH_ID    = 3'd4;
    localparam logic [2:0] KIND_FLUSH_SLOT  = 3'd5;
    localparam logic [2:0] KIND_FLUSH_ALL   = 3'd6;
    localparam logic [2:0] KIND_UNUSED      = 3'd7;

    // result command codes
    localparam logic [1:0] CMD_WRITEBACK = 2'd0;
    localparam logic [1:0] CMD_READ      = 2'd1;
    localparam logic [1:0] CMD_STATUS    = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] block_id;
        logic [3:0]  slot_index;
        logic        writeback_fails;
        logic        read_fails;
    } t_item;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot_out;
        logic [31:0] block_out;
        logic        failed;
        logic        hit;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WAIT,
        ST_VICTIM,
        ST_READ,
        ST_STATUS
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/wbcc_cell.sv
`default_nettype none

module wbcc_cell
    import wbcc_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_shift,
    input  wire logic [ID_BITS-1:0] i_tag,
    input  wire logic               i_valid,
    input  wire logic               i_dirty,
    output logic      [ID_BITS-1:0] o_tag,
    output logic                    o_valid,
    output logic                    o_dirty
);

    logic [ID_BITS-1:0] r_tag;
    logic               r_valid;
    logic               r_dirty;

    // flags are cleared on reset, the tag is only read while valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
            r_dirty <= i_dirty;
        end
    end

    // tag moves with its flags
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tag <= i_tag;
        end
    end

    assign o_tag   = r_tag;
    assign o_valid = r_valid;
    assign o_dirty = r_dirty;

endmodule

`default_nettype wire

>>> rtl/core/wbcc_mod.sv
`default_nettype none

module wbcc_mod
    import wbcc_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF,
    parameter int SLOTS   = SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ID_BITS-1:0]           i_dividend,
    input  wire logic [$clog2(SLOTS+1)-1:0]   i_divisor,
    output logic                              o_done,
    output logic      [$clog2(SLOTS+1)-1:0]   o_rem
);

    localparam int CW    = $clog2(SLOTS + 1);
    localparam int STEPS = (ID_BITS + MOD_DIGITS - 1) / MOD_DIGITS;
    localparam int PADW  = STEPS * MOD_DIGITS;
    localparam int SW    = $clog2(STEPS + 1);

    logic [PADW-1:0] r_sh;
    logic [CW-1:0]   r_rem;
    logic [CW-1:0]   r_div;
    logic [SW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   n_rem;

    // restoring remainder, a few bits per cycle from the top
    always_comb begin
        logic [CW:0] t;
        n_rem = r_rem;
        for (int j = 0; j < MOD_DIGITS; j++) begin
            t = {n_rem, r_sh[PADW-1-j]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[CW-1:0];
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= SW'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == SW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // operand and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= PADW'(i_dividend);
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= r_sh << MOD_DIGITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/core/writeback_block_cache_controller_core.sv
`default_nettype none

// channel   | direction | handshake                 | word
// ----------+-----------+---------------------------+-------------------------
// item      | in        | start high, busy low      | i_item (t_item)
// result    | out       | o_res_valid, one cycle    | o_res (t_result)
// config    | in        | i_cfg_valid & o_cfg_ready | i_cfg_data (active slots)
//
// slot entries sit in a ring of cells that rotates one place per cycle in the
// search and victim passes; a pass brings the ring back home. the unused kind
// goes straight to its status word, the others make a search pass first. a get
// or claim miss adds a victim pass, waiting first for the remainder unit if it
// is not yet done; a get whose victim write-back did not fail adds a read word.
// reset clears all valid and dirty bits at once; results cannot be stalled.
module writeback_block_cache_controller_core
    import wbcc_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_item      i_item,
    output logic            o_res_valid,
    output t_result         o_res,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [4:0] i_cfg_data
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic               r_found, n_found;
    logic [CW-1:0]      r_fidx, n_fidx;
    logic               r_failed, n_failed;
    logic               r_rd_pend, n_rd_pend;
    t_result            r_res, n_res;
    logic               r_res_v, n_res_v;
    logic [4:0]         r_active;

    logic [2:0]         r_kind;
    logic [31:0]        r_echo;
    logic [ID_BITS-1:0] r_id;
    logic [3:0]         r_sidx;
    logic               r_wfail;
    logic               r_rfail;
    logic [CW-1:0]      r_nact;

    logic [CW-1:0]      nact_in;
    logic               accept;
    logic               shift;
    logic               in_range;
    logic               id_match;
    logic               slot_match;
    logic               pass_end;
    logic               is_id_kind;
    logic               is_dirty_kind;
    logic               mod_done;
    logic [CW-1:0]      mod_rem;

    logic [ID_BITS-1:0] c_tag   [SLOTS];
    logic               c_valid [SLOTS];
    logic               c_dirty [SLOTS];
    logic [ID_BITS-1:0] n_head_tag;
    logic               n_head_valid;
    logic               n_head_dirty;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // clamp the active slot count
    always_comb begin
        if (r_active == 5'd0) begin
            nact_in = CW'(1);
        end else if (XW'(r_active) > XW'(SLOTS)) begin
            nact_in = CW'(SLOTS);
        end else begin
            nact_in = CW'(r_active);
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_item.kind;
            r_echo  <= i_item.block_id;
            r_id    <= ID_BITS'(i_item.block_id);
            r_sidx  <= i_item.slot_index;
            r_wfail <= i_item.writeback_fails;
            r_rfail <= i_item.read_fails;
            r_nact  <= nact_in;
        end
    end

    // victim placement remainder
    wbcc_mod #(
        .ID_BITS (ID_BITS),
        .SLOTS   (SLOTS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (ID_BITS'(i_item.block_id)),
        .i_divisor  (nact_in),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // ring of slot cells, the head feeds the tail
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        if (k == SLOTS - 1) begin : g_tail
            wbcc_cell #(.ID_BITS(ID_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_tag   (n_head_tag),
                .i_valid (n_head_valid),
                .i_dirty (n_head_dirty),
                .o_tag   (c_tag[k]),
                .o_valid (c_valid[k]),
                .o_dirty (c_dirty[k])
            );
        end else begin : g_body
            wbcc_cell #(.ID_BITS(ID_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_tag   (c_tag[k+1]),
                .i_valid (c_valid[k+1]),
                .i_dirty (c_dirty[k+1]),
                .o_tag   (c_tag[k]),
                .o_valid (c_valid[k]),
                .o_dirty (c_dirty[k])
            );
        end
    end

    // head compares
    assign in_range      = (r_ptr < r_nact);
    assign id_match      = in_range && c_valid[0] && (c_tag[0] == r_id);
    assign slot_match    = in_range && c_valid[0] && (XW'(r_ptr) == XW'(r_sidx));
    assign pass_end      = (r_ptr == CW'(SLOTS - 1));
    assign is_id_kind    = (r_kind == KIND_DIRTY_ID) || (r_kind == KIND_FLUSH_ID);
    assign is_dirty_kind = (r_kind == KIND_DIRTY_ID) || (r_kind == KIND_DIRTY_SLOT);

    // sequencer and head update
    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_found      = r_found;
        n_fidx       = r_fidx;
        n_failed     = r_failed;
        n_rd_pend    = r_rd_pend;
        n_res        = r_res;
        n_res_v      = 1'b0;
        shift        = 1'b0;
        n_head_tag   = c_tag[0];
        n_head_valid = c_valid[0];
        n_head_dirty = c_dirty[0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_ptr     = '0;
                    n_found   = 1'b0;
                    n_fidx    = '0;
                    n_failed  = 1'b0;
                    n_rd_pend = 1'b0;
                    n_state   = (i_item.kind == KIND_UNUSED) ? ST_STATUS : ST_SEARCH;
                end
            end

            ST_SEARCH: begin
                shift = 1'b1;
                n_ptr = pass_end ? '0 : r_ptr + 1'b1;
                case (r_kind) inside
                    KIND_GET, KIND_CLAIM: begin
                        if (id_match && !r_found) begin
                            n_found = 1'b1;
                            n_fidx  = r_ptr;
                        end
                    end
                    KIND_DIRTY_ID, KIND_FLUSH_ID, KIND_DIRTY_SLOT, KIND_FLUSH_SLOT: begin
                        if (is_id_kind ? (id_match && !r_found) : slot_match) begin
                            n_found = 1'b1;
                            n_fidx  = r_ptr;
                            if (is_dirty_kind) begin
                                n_head_dirty = 1'b1;
                            end else if (c_dirty[0]) begin
                                n_res_v = 1'b1;
                                n_res   = '{command: CMD_WRITEBACK, slot_out: 4'(r_ptr),
                                            block_out: 32'(c_tag[0]), failed: 1'b0,
                                            hit: 1'b0, last: 1'b0};
                                if (r_wfail) begin
                                    n_failed = 1'b1;
                                end else begin
                                    n_head_dirty = 1'b0;
                                end
                            end
                        end
                    end
                    KIND_FLUSH_ALL: begin
                        if (in_range && !r_failed && c_valid[0] && c_dirty[0]) begin
                            n_res_v = 1'b1;
                            n_res   = '{command: CMD_WRITEBACK, slot_out: 4'(r_ptr),
                                        block_out: 32'(c_tag[0]), failed: 1'b0,
                                        hit: 1'b0, last: 1'b0};
                            if (r_wfail) begin
                                n_failed = 1'b1;
                                n_fidx   = r_ptr;
                            end else begin
                                n_head_dirty = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (pass_end) begin
                    if (((r_kind == KIND_GET) || (r_kind == KIND_CLAIM)) && !n_found) begin
                        n_state = mod_done ? ST_VICTIM : ST_WAIT;
                    end else begin
                        n_state = ST_STATUS;
                    end
                end
            end

            ST_WAIT: begin
                if (mod_done) begin
                    n_state = ST_VICTIM;
                end
            end

            ST_VICTIM: begin
                shift = 1'b1;
                n_ptr = pass_end ? '0 : r_ptr + 1'b1;
                if (r_ptr == mod_rem) begin
                    n_fidx = r_ptr;
                    if (c_valid[0] && c_dirty[0]) begin
                        n_res_v = 1'b1;
                        n_res   = '{command: CMD_WRITEBACK, slot_out: 4'(r_ptr),
                                    block_out: 32'(c_tag[0]), failed: 1'b0,
                                    hit: 1'b0, last: 1'b0};
                    end
                    if (r_kind == KIND_CLAIM) begin
                        n_head_tag   = r_id;
                        n_head_valid = 1'b1;
                        n_head_dirty = 1'b1;
                    end else if (c_valid[0] && c_dirty[0] && r_wfail) begin
                        n_failed = 1'b1;
                    end else begin
                        n_rd_pend    = 1'b1;
                        n_head_dirty = 1'b0;
                        if (r_rfail) begin
                            n_failed = 1'b1;
                        end else begin
                            n_head_tag   = r_id;
                            n_head_valid = 1'b1;
                        end
                    end
                end
                if (pass_end) begin
                    n_state = n_rd_pend ? ST_READ : ST_STATUS;
                end
            end

            ST_READ: begin
                n_res_v = 1'b1;
                n_res   = '{command: CMD_READ, slot_out: 4'(r_fidx), block_out: 32'(r_id),
                            failed: 1'b0, hit: 1'b0, last: 1'b0};
                n_state = ST_STATUS;
            end

            ST_STATUS: begin
                n_res_v = 1'b1;
                n_res.command   = CMD_STATUS;
                n_res.block_out = r_echo;
                n_res.failed    = r_failed;
                n_res.last      = 1'b1;
                if ((r_kind == KIND_DIRTY_SLOT) || (r_kind == KIND_FLUSH_SLOT)) begin
                    n_res.slot_out = r_sidx;
                end else begin
                    n_res.slot_out = 4'(r_fidx);
                end
                if ((r_kind == KIND_FLUSH_ALL) || (r_kind == KIND_UNUSED)) begin
                    n_res.hit = 1'b0;
                end else begin
                    n_res.hit = r_found;
                end
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ptr     <= '0;
            r_found   <= 1'b0;
            r_fidx    <= '0;
            r_failed  <= 1'b0;
            r_rd_pend <= 1'b0;
            r_res_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_found   <= n_found;
            r_fidx    <= n_fidx;
            r_failed  <= n_failed;
            r_rd_pend <= n_rd_pend;
            r_res_v   <= n_res_v;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

    // final status shows only once the block is free again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> !busy)
        else $error("final status while still busy");

    // commands always come before the final status of their item
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.command != CMD_STATUS)) |-> busy)
        else $error("command word after item completion");

    // an accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("item accepted but block not busy");

    // the ring is back in home position whenever idle
    a_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_ptr == '0))
        else $error("slot ring not aligned while idle");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    import wbcc_pkg::*;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_item      i_item      = '0;
    logic       o_res_valid;
    t_result    o_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [4:0] i_cfg_data  = 5'd0;

    writeback_block_cache_controller_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the tag store and the active slot register
    logic [31:0] line_tag   [0:15];
    logic        line_valid [0:15];
    logic        line_dirty [0:15];
    logic [4:0]  slots_reg  = ACTIVE_RESET;

    t_item       pend_q    [$];
    t_result     outcome_q [$];
    logic [31:0] id_pool   [0:19];
    logic        steady = 1'b0;
    int          n_errors = 0;

    initial begin
        for (int i = 0; i < 16; i++) begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
        end
    end

    // slots in use: zero acts as one, anything above 16 as 16
    function automatic logic [31:0] slots_in_use();
        if (slots_reg == 5'd0) return 32'd1;
        if (slots_reg > 5'd16) return 32'd16;
        return {27'd0, slots_reg};
    endfunction

    function automatic void emit(logic [1:0] cmd, int slot, logic [31:0] blk,
                                 logic failed, logic hit, logic last);
        t_result r;
        r.command   = cmd;
        r.slot_out  = slot[3:0];
        r.block_out = blk;
        r.failed    = failed;
        r.hit       = hit;
        r.last      = last;
        outcome_q.push_back(r);
    endfunction

    function automatic int find_line(logic [31:0] id);
        logic [31:0] n;
        n = slots_in_use();
        for (int i = 0; i < n; i++)
            if (line_valid[i] && line_tag[i] == id) return i;
        return -1;
    endfunction

    // write back a valid dirty line; returns 1 when the store rejects it
    function automatic logic spill_line(int s, logic fails);
        if (line_valid[s] && line_dirty[s]) begin
            emit(CMD_WRITEBACK, s, line_tag[s], 1'b0, 1'b0, 1'b0);
            if (fails) return 1'b1;
            line_dirty[s] = 1'b0;
        end
        return 1'b0;
    endfunction

    // expected command and status words of one accepted item
    function automatic void cache_outcome(t_item it);
        logic [31:0] nact;
        int          s;
        int          v;
        int          i;
        logic        f;
        logic        stopped;
        nact = slots_in_use();
        case (it.kind)
            KIND_GET, KIND_CLAIM: begin
                s = find_line(it.block_id);
                if (s >= 0) begin
                    emit(CMD_STATUS, s, it.block_id, 1'b0, 1'b1, 1'b1);
                end else begin
                    v = int'(it.block_id % nact);
                    f = spill_line(v, it.writeback_fails);
                    if (it.kind == KIND_CLAIM) begin
                        line_tag[v]   = it.block_id;
                        line_valid[v] = 1'b1;
                        line_dirty[v] = 1'b1;
                        emit(CMD_STATUS, v, it.block_id, 1'b0, 1'b0, 1'b1);
                    end else if (f) begin
                        emit(CMD_STATUS, v, it.block_id, 1'b1, 1'b0, 1'b1);
                    end else begin
                        emit(CMD_READ, v, it.block_id, 1'b0, 1'b0, 1'b0);
                        if (it.read_fails) begin
                            emit(CMD_STATUS, v, it.block_id, 1'b1, 1'b0, 1'b1);
                        end else begin
                            line_tag[v]   = it.block_id;
                            line_valid[v] = 1'b1;
                            line_dirty[v] = 1'b0;
                            emit(CMD_STATUS, v, it.block_id, 1'b0, 1'b0, 1'b1);
                        end
                    end
                end
            end
            KIND_DIRTY_ID, KIND_FLUSH_ID: begin
                s = find_line(it.block_id);
                if (s < 0) begin
                    emit(CMD_STATUS, 0, it.block_id, 1'b0, 1'b0, 1'b1);
                end else if (it.kind == KIND_DIRTY_ID) begin
                    line_dirty[s] = 1'b1;
                    emit(CMD_STATUS, s, it.block_id, 1'b0, 1'b1, 1'b1);
                end else begin
                    f = spill_line(s, it.writeback_fails);
                    emit(CMD_STATUS, s, it.block_id, f, 1'b1, 1'b1);
                end
            end
            KIND_DIRTY_SLOT, KIND_FLUSH_SLOT: begin
                s = int'(it.slot_index);
                if (s >= nact || !line_valid[s]) begin
                    emit(CMD_STATUS, s, it.block_id, 1'b0, 1'b0, 1'b1);
                end else if (it.kind == KIND_DIRTY_SLOT) begin
                    line_dirty[s] = 1'b1;
                    emit(CMD_STATUS, s, it.block_id, 1'b0, 1'b1, 1'b1);
                end else begin
                    f = spill_line(s, it.writeback_fails);
                    emit(CMD_STATUS, s, it.block_id, f, 1'b1, 1'b1);
                end
            end
            KIND_FLUSH_ALL: begin
                stopped = 1'b0;
                for (i = 0; i < nact && !stopped; i++) begin
                    if (spill_line(i, it.writeback_fails)) begin
                        emit(CMD_STATUS, i, it.block_id, 1'b1, 1'b0, 1'b1);
                        stopped = 1'b1;
                    end
                end
                if (!stopped) emit(CMD_STATUS, 0, it.block_id, 1'b0, 1'b0, 1'b1);
            end
            default: begin
                emit(CMD_STATUS, 0, it.block_id, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic void queue_op(logic [2:0] kind, logic [31:0] id, logic [3:0] slot,
                                     logic wfail, logic rfail);
        t_item it;
        it.kind            = kind;
        it.block_id        = id;
        it.slot_index      = slot;
        it.writeback_fails = wfail;
        it.read_fails      = rfail;
        pend_q.push_back(it);
    endfunction

    // mostly ids from a small pool so that hits, victims and write-backs recur
    function automatic t_item random_op();
        t_item it;
        int    r;
        r = $urandom_range(99);
        if (r < 28)      it.kind = KIND_GET;
        else if (r < 46) it.kind = KIND_CLAIM;
        else if (r < 56) it.kind = KIND_DIRTY_ID;
        else if (r < 64) it.kind = KIND_DIRTY_SLOT;
        else if (r < 76) it.kind = KIND_FLUSH_ID;
        else if (r < 84) it.kind = KIND_FLUSH_SLOT;
        else if (r < 93) it.kind = KIND_FLUSH_ALL;
        else             it.kind = KIND_UNUSED;
        if ($urandom_range(99) < 80) it.block_id = id_pool[$urandom_range(19)];
        else                         it.block_id = $urandom;
        it.slot_index      = 4'($urandom_range(15));
        it.writeback_fails = ($urandom_range(99) < 25);
        it.read_fails      = ($urandom_range(99) < 25);
        return it;
    endfunction

    // item driver: hold start until the word is taken, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) cache_outcome(i_item);
            if (!(start && busy)) begin
                if (pend_q.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
                    start  <= 1'b1;
                    i_item <= pend_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    // result monitor: every strobed word against the oldest prediction
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_res_valid) begin
            if (outcome_q.size() == 0) begin
                $error("result word with nothing predicted: 0x%0h", o_res);
                n_errors++;
            end else begin
                w = outcome_q.pop_front();
                check_field("command",   32'(w.command),  32'(o_res.command));
                check_field("slot_out",  32'(w.slot_out), 32'(o_res.slot_out));
                check_field("block_out", w.block_out,     o_res.block_out);
                check_field("failed",    32'(w.failed),   32'(o_res.failed));
                check_field("hit",       32'(w.hit),      32'(o_res.hit));
                check_field("last",      32'(w.last),     32'(o_res.last));
            end
        end
    end

    task automatic drain();
        @(negedge i_clk);
        while (pend_q.size() != 0 || start || outcome_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_active(logic [4:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        slots_reg    = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [4:0] phase_slots [0:5];
        phase_slots = '{5'd31, 5'd1, 5'd7, 5'd16, 5'd12, 5'd3};
        for (int i = 0; i < 20; i++)
            id_pool[i] = (i < 8) ? 32'($urandom_range(40)) : $urandom;
        id_pool[0] = 32'hFFFF_FFFF;
        id_pool[1] = 32'h8000_0000;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: miss then hit, dirty victim, failing write-back and read
        queue_op(KIND_GET,        32'h0000_0000, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_GET,        32'h0000_0000, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_CLAIM,      32'hFFFF_FFFF, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_GET,        32'h0000_001F, 4'd0,  1'b1, 1'b0);
        queue_op(KIND_GET,        32'h0000_001F, 4'd0,  1'b0, 1'b1);
        queue_op(KIND_DIRTY_ID,   32'hFFFF_FFFF, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_CLAIM,      32'h0000_002F, 4'd0,  1'b1, 1'b0);
        queue_op(KIND_DIRTY_SLOT, 32'hAAAA_AAAA, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_DIRTY_SLOT, 32'h5555_5555, 4'd3,  1'b0, 1'b0);
        queue_op(KIND_DIRTY_ID,   32'h1234_5678, 4'd15, 1'b1, 1'b1);
        queue_op(KIND_FLUSH_ID,   32'h0000_0000, 4'd0,  1'b1, 1'b0);
        queue_op(KIND_FLUSH_ID,   32'h0000_0000, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_FLUSH_ID,   32'h0000_0000, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_FLUSH_SLOT, 32'h0000_0000, 4'd15, 1'b0, 1'b0);
        queue_op(KIND_FLUSH_SLOT, 32'h0000_0000, 4'd9,  1'b0, 1'b0);
        queue_op(KIND_CLAIM,      32'h0000_0022, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_CLAIM,      32'h0000_0033, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_FLUSH_ALL,  32'hAAAA_AAAA, 4'd0,  1'b1, 1'b0);
        queue_op(KIND_FLUSH_ALL,  32'h5555_5555, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_UNUSED,     32'hDEAD_BEEF, 4'd7,  1'b1, 1'b1);
        queue_op(KIND_GET,        32'hAAAA_AAAA, 4'd10, 1'b0, 1'b0);
        drain();

        // zero active slots acts as one: out of range slot misses
        write_active(5'd0);
        queue_op(KIND_CLAIM,      32'h0000_0005, 4'd0,  1'b0, 1'b0);
        queue_op(KIND_FLUSH_SLOT, 32'h0000_0005, 4'd3,  1'b0, 1'b0);
        queue_op(KIND_FLUSH_ALL,  32'h0000_0005, 4'd0,  1'b0, 1'b0);
        drain();

        // random phases over several slot counts, one with no idling
        for (int ph = 0; ph < 6; ph++) begin
            write_active(phase_slots[ph]);
            steady = (ph == 3);
            for (int i = 0; i < 4; i++) id_pool[2 + $urandom_range(17)] = $urandom;
            for (int i = 0; i < 24; i++) pend_q.push_back(random_op());
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            $error("%0d predicted words never arrived", outcome_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #3000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/wbcc_pkg.sv
rtl/core/wbcc_cell.sv
rtl/core/wbcc_mod.sv
rtl/core/writeback_block_cache_controller_core.sv
tb/sv/tb_top.sv
